@@ rtl/core/mdc_pkg.sv @@
// Shared types and constants for the two-axis ramped motor direction control unit.
// Holds the command codes, register indexes and the request and view structs.
// No dependencies.
package mdc_pkg;

  typedef logic [7:0] duty_t;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_RA_SPEED       = 2'd0;
  localparam cfg_index_t CFG_DEC_SPEED      = 2'd1;
  localparam cfg_index_t CFG_DEBOUNCE_TICKS = 2'd2;

  localparam duty_t RA_SPEED_RESET       = 8'd190;
  localparam duty_t DEC_SPEED_RESET      = 8'd190;
  localparam duty_t DEBOUNCE_TICKS_RESET = 8'd125;

  localparam logic [7:0] CMD_RA_PLUS_START   = 8'hF2;
  localparam logic [7:0] CMD_RA_PLUS_STOP    = 8'hF3;
  localparam logic [7:0] CMD_RA_MINUS_START  = 8'hF4;
  localparam logic [7:0] CMD_RA_MINUS_STOP   = 8'hF5;
  localparam logic [7:0] CMD_DEC_PLUS_START  = 8'hF8;
  localparam logic [7:0] CMD_DEC_PLUS_STOP   = 8'hF9;
  localparam logic [7:0] CMD_DEC_MINUS_START = 8'hFA;
  localparam logic [7:0] CMD_DEC_MINUS_STOP  = 8'hFB;

  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_START,
    REQ_STOP
  } req_kind_t;

  // Requests for one axis, applied plus direction first, then minus.
  typedef struct packed {
    req_kind_t plus_req;
    req_kind_t minus_req;
  } axis_req_t;

  // Outputs of one axis after the current transaction has been applied.
  typedef struct packed {
    duty_t plus_duty;
    duty_t minus_duty;
    logic  plus_led;
    logic  minus_led;
  } axis_view_t;

endpackage

@@ rtl/core/mdc_buttons.sv @@
// Button debounce and latch logic for the four direction buttons.
// Produces start and stop requests for both axes; depends on mdc_pkg.
module mdc_buttons (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  update,
  input  logic [3:0]            levels,
  input  mdc_pkg::duty_t        debounce_ticks,
  output mdc_pkg::axis_req_t    ra_req,
  output mdc_pkg::axis_req_t    dec_req
);

  logic [7:0]          hold_r   [4];
  logic [7:0]          hold_nxt [4];
  logic [3:0]          latch_r;
  logic [3:0]          latch_nxt;
  mdc_pkg::req_kind_t  btn_req  [4];
  mdc_pkg::duty_t      need;

  assign need = (debounce_ticks == 8'd0) ? 8'd1 : debounce_ticks;

  // Buttons are handled in order, so a later button sees the latches of earlier ones.
  always_comb begin
    logic [1:0] bi;
    bi        = 2'd0;
    latch_nxt = latch_r;
    for (int b = 0; b < 4; b++) begin
      bi          = 2'(b);
      hold_nxt[b] = hold_r[b];
      btn_req[b]  = mdc_pkg::REQ_NONE;
      if (levels[bi]) begin
        if (hold_r[b] < need) begin
          hold_nxt[b] = hold_r[b] + 8'd1;
        end
        if ((hold_nxt[b] >= need) && !latch_nxt[bi ^ 2'd1]) begin
          btn_req[b]    = mdc_pkg::REQ_START;
          latch_nxt[bi] = 1'b1;
        end
      end else begin
        hold_nxt[b] = 8'd0;
        if (latch_r[bi]) begin
          btn_req[b]    = mdc_pkg::REQ_STOP;
          latch_nxt[bi] = 1'b0;
        end
      end
    end
  end

  assign ra_req  = '{plus_req: btn_req[0], minus_req: btn_req[1]};
  assign dec_req = '{plus_req: btn_req[2], minus_req: btn_req[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 4; b++) begin
        hold_r[b] <= 8'd0;
      end
      latch_r <= 4'd0;
    end else if (update) begin
      for (int b = 0; b < 4; b++) begin
        hold_r[b] <= hold_nxt[b];
      end
      latch_r <= latch_nxt;
    end
  end

endmodule

@@ rtl/core/mdc_axis.sv @@
// One motor axis: direction interlock, mode sequencing and duty ramp.
// Applies the requests of one transaction and reports the resulting duties; depends on mdc_pkg.
module mdc_axis (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  update,
  input  logic                  tick,
  input  mdc_pkg::axis_req_t    req,
  input  mdc_pkg::duty_t        speed,
  output mdc_pkg::axis_view_t   view
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_UP,
    MODE_RUN,
    MODE_DOWN
  } mode_t;

  mode_t          mode_r;
  mode_t          mode_nxt;
  logic           dir_r;
  logic           dir_nxt;
  mdc_pkg::duty_t duty_r;
  mdc_pkg::duty_t duty_nxt;

  always_comb begin
    mode_nxt = mode_r;
    dir_nxt  = dir_r;
    duty_nxt = duty_r;

    if ((req.plus_req == mdc_pkg::REQ_START) && (mode_nxt == MODE_IDLE)) begin
      mode_nxt = MODE_UP;
      dir_nxt  = 1'b0;
    end else if ((req.plus_req == mdc_pkg::REQ_STOP) && !dir_nxt &&
                 ((mode_nxt == MODE_UP) || (mode_nxt == MODE_RUN))) begin
      mode_nxt = MODE_DOWN;
    end

    if ((req.minus_req == mdc_pkg::REQ_START) && (mode_nxt == MODE_IDLE)) begin
      mode_nxt = MODE_UP;
      dir_nxt  = 1'b1;
    end else if ((req.minus_req == mdc_pkg::REQ_STOP) && dir_nxt &&
                 ((mode_nxt == MODE_UP) || (mode_nxt == MODE_RUN))) begin
      mode_nxt = MODE_DOWN;
    end

    if (tick) begin
      unique case (mode_nxt)
        MODE_UP, MODE_RUN: begin
          if (duty_nxt < speed) begin
            duty_nxt = duty_nxt + 8'd1;
          end else if (duty_nxt > speed) begin
            duty_nxt = duty_nxt - 8'd1;
          end
          if (duty_nxt == speed) begin
            mode_nxt = MODE_RUN;
          end
        end
        MODE_DOWN: begin
          if (duty_nxt != 8'd0) begin
            duty_nxt = duty_nxt - 8'd1;
          end
          if (duty_nxt == 8'd0) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_IDLE: begin
          duty_nxt = duty_r;
        end
        default: begin
          duty_nxt = duty_r;
        end
      endcase
    end
  end

  always_comb begin
    view.plus_duty  = ((mode_nxt != MODE_IDLE) && !dir_nxt) ? duty_nxt : 8'd0;
    view.minus_duty = ((mode_nxt != MODE_IDLE) && dir_nxt) ? duty_nxt : 8'd0;
    view.plus_led   = ((mode_nxt == MODE_UP) || (mode_nxt == MODE_RUN)) && !dir_nxt;
    view.minus_led  = ((mode_nxt == MODE_UP) || (mode_nxt == MODE_RUN)) && dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dir_r  <= 1'b0;
      duty_r <= 8'd0;
    end else if (update) begin
      mode_r <= mode_nxt;
      dir_r  <= dir_nxt;
      duty_r <= duty_nxt;
    end
  end

endmodule

@@ rtl/core/two_axis_ramped_motor_direction_control_unit.sv @@
// Top level of the two-axis ramped motor direction control unit.
// Holds the input and result registers, the configuration registers and command decode;
// depends on mdc_pkg, mdc_buttons and mdc_axis.
//
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid/in_tready    in_tdata, in_tuser
//  out_     master     out_tvalid/out_tready  out_tdata, out_tuser
//  cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An accepted transaction waits in the input register and then passes the one update stage
// into the result register; one may be accepted in every cycle unless the result stalls.
// Reset (synchronous, active low) clears axis and button state and restores config defaults.
// A stalled result register holds the input register; in_tready falls only while both hold
// a transaction and the result is not taken. Configuration writes are accepted in every cycle.
module two_axis_ramped_motor_direction_control_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,   // cmd_byte[7:0], buttons[11:8], zero[15:12]
  input  logic                      in_tuser,   // op
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [39:0]               out_tdata,  // ra_plus_duty, ra_minus_duty, dec_plus_duty,
                                                // dec_minus_duty, leds[35:32], zero[39:36]
  output logic                      out_tuser,  // ack
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  mdc_pkg::cfg_index_t       cfg_index,
  input  logic [7:0]                cfg_data
);

  logic                 in_valid_r;
  logic                 in_op_r;
  logic [7:0]           in_cmd_r;
  logic [3:0]           in_btn_r;
  logic                 out_valid_r;
  logic [39:0]          out_data_r;
  logic                 out_ack_r;
  mdc_pkg::duty_t       ra_speed_r;
  mdc_pkg::duty_t       dec_speed_r;
  mdc_pkg::duty_t       debounce_r;
  logic                 advance;
  logic                 tick;
  logic                 ack;
  mdc_pkg::axis_req_t   ra_cmd_req;
  mdc_pkg::axis_req_t   dec_cmd_req;
  mdc_pkg::axis_req_t   ra_btn_req;
  mdc_pkg::axis_req_t   dec_btn_req;
  mdc_pkg::axis_req_t   ra_req;
  mdc_pkg::axis_req_t   dec_req;
  mdc_pkg::axis_view_t  ra_view;
  mdc_pkg::axis_view_t  dec_view;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign tick      = !in_op_r;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ack_r;

  always_comb begin
    ra_cmd_req  = '{plus_req: mdc_pkg::REQ_NONE, minus_req: mdc_pkg::REQ_NONE};
    dec_cmd_req = '{plus_req: mdc_pkg::REQ_NONE, minus_req: mdc_pkg::REQ_NONE};
    ack         = 1'b1;
    unique case (in_cmd_r)
      mdc_pkg::CMD_RA_PLUS_START:   ra_cmd_req.plus_req   = mdc_pkg::REQ_START;
      mdc_pkg::CMD_RA_PLUS_STOP:    ra_cmd_req.plus_req   = mdc_pkg::REQ_STOP;
      mdc_pkg::CMD_RA_MINUS_START:  ra_cmd_req.minus_req  = mdc_pkg::REQ_START;
      mdc_pkg::CMD_RA_MINUS_STOP:   ra_cmd_req.minus_req  = mdc_pkg::REQ_STOP;
      mdc_pkg::CMD_DEC_PLUS_START:  dec_cmd_req.plus_req  = mdc_pkg::REQ_START;
      mdc_pkg::CMD_DEC_PLUS_STOP:   dec_cmd_req.plus_req  = mdc_pkg::REQ_STOP;
      mdc_pkg::CMD_DEC_MINUS_START: dec_cmd_req.minus_req = mdc_pkg::REQ_START;
      mdc_pkg::CMD_DEC_MINUS_STOP:  dec_cmd_req.minus_req = mdc_pkg::REQ_STOP;
      default:                      ack                   = 1'b0;
    endcase
  end

  assign ra_req  = tick ? ra_btn_req : ra_cmd_req;
  assign dec_req = tick ? dec_btn_req : dec_cmd_req;

  mdc_buttons u_buttons (
    .clk            (clk),
    .rst_n          (rst_n),
    .update         (advance && tick),
    .levels         (in_btn_r),
    .debounce_ticks (debounce_r),
    .ra_req         (ra_btn_req),
    .dec_req        (dec_btn_req)
  );

  mdc_axis u_ra_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .update (advance),
    .tick   (tick),
    .req    (ra_req),
    .speed  (ra_speed_r),
    .view   (ra_view)
  );

  mdc_axis u_dec_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .update (advance),
    .tick   (tick),
    .req    (dec_req),
    .speed  (dec_speed_r),
    .view   (dec_view)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ra_speed_r  <= mdc_pkg::RA_SPEED_RESET;
      dec_speed_r <= mdc_pkg::DEC_SPEED_RESET;
      debounce_r  <= mdc_pkg::DEBOUNCE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mdc_pkg::CFG_RA_SPEED:       ra_speed_r  <= cfg_data;
        mdc_pkg::CFG_DEC_SPEED:      dec_speed_r <= cfg_data;
        mdc_pkg::CFG_DEBOUNCE_TICKS: debounce_r  <= cfg_data;
        default:                     debounce_r  <= debounce_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      out_valid_r <= advance || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r  <= in_tuser;
      in_cmd_r <= in_tdata[7:0];
      in_btn_r <= in_tdata[11:8];
    end
    if (advance) begin
      out_data_r <= {4'd0, dec_view.minus_led, dec_view.plus_led, ra_view.minus_led,
                     ra_view.plus_led, dec_view.minus_duty, dec_view.plus_duty,
                     ra_view.minus_duty, ra_view.plus_duty};
      out_ack_r  <= in_op_r && ack;
    end
  end

`ifndef SYNTHESIS
  a_ra_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !((out_tdata[7:0] != 8'd0) && (out_tdata[15:8] != 8'd0)))
    else $error("ra axis drives both directions");

  a_dec_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !((out_tdata[23:16] != 8'd0) && (out_tdata[31:24] != 8'd0)))
    else $error("dec axis drives both directions");

  a_led_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[32] && out_tdata[33]) && !(out_tdata[34] && out_tdata[35]))
    else $error("two directions of one axis flagged active");

  a_tick_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_op_r) |=> !out_tuser)
    else $error("acknowledge raised for a tick transaction");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled while a register was free");
`endif

endmodule
